// File: rtl/gmpe_pkg.sv
// gmpe_pkg: shared types and constants of the memory polynomial evaluator
// used by gmpe_sqrt and gmp_model_evaluator; no dependencies

package gmpe_pkg;

  // field widths of the request and result channels
  localparam int unsigned SampleW = 16;
  localparam int unsigned CoefW   = 18;
  localparam int unsigned CidxW   = 9;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgW    = 4;

  // arithmetic widths
  localparam int unsigned MulW    = 26;  // shared multiplier operands
  localparam int unsigned ProdW   = 2 * MulW;
  localparam int unsigned PwrW    = 24;  // envelope power, Q.15
  localparam int unsigned TermW   = 26;  // sample times power, Q.15
  localparam int unsigned AccW    = 56;  // Q.30 accumulator
  localparam int unsigned RadW    = 32;  // squared magnitude
  localparam int unsigned RootW   = 17;  // rounded magnitude
  localparam int unsigned NeedW   = 8;

  localparam logic [PwrW-1:0] PwrOne = PwrW'(32768);

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ALIGNED_ORDER = 4'd0,
    CFG_ALIGNED_DEPTH = 4'd1,
    CFG_LAG_ORDER     = 4'd2,
    CFG_LAG_DEPTH     = 4'd3,
    CFG_LAG_SPAN      = 4'd4,
    CFG_LEAD_ORDER    = 4'd5,
    CFG_LEAD_DEPTH    = 4'd6,
    CFG_LEAD_SPAN     = 4'd7
  } cfg_idx_e;

  // request modes
  typedef enum logic {
    MODE_COEF   = 1'b0,
    MODE_SAMPLE = 1'b1
  } mode_e;

  // term groups in evaluation order
  typedef enum logic [1:0] {
    SEC_ALIGNED = 2'd0,
    SEC_LAG     = 2'd1,
    SEC_LEAD    = 2'd2,
    SEC_DONE    = 2'd3
  } sec_e;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_SETUP,
    S_CHECK,
    S_ADV,
    S_ENV_RD,
    S_SQ_RE,
    S_SQ_IM,
    S_SQ_SUM,
    S_SQRT_GO,
    S_SQRT,
    S_POW,
    S_POW_WR,
    S_X_RD,
    S_XT_RE,
    S_XT_IM,
    S_M1,
    S_M2,
    S_M3,
    S_M4,
    S_M5,
    S_FINISH
  } state_e;

  // square root unit handshake
  typedef struct packed {
    logic start;
    logic [RadW-1:0] radicand;
  } sqrt_req_t;

endpackage

// File: rtl/gmpe_ram.sv
// gmpe_ram: generic single write port memory with registered read
// no dependencies

module gmpe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/gmpe_sqrt.sv
// gmpe_sqrt: iterative square root, one result bit per cycle, rounded to nearest
// depends on gmpe_pkg

module gmpe_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  gmpe_pkg::sqrt_req_t        req_i,
  output logic                       done_o,
  output logic [gmpe_pkg::RootW-1:0] root_o
);

  localparam int unsigned RW = gmpe_pkg::RadW;

  logic          busy_q;
  logic          done_q;
  logic [RW-1:0] rem_q, rem_d;
  logic [RW-1:0] r_q, r_d;
  logic [RW-2:0] b_q;
  logic [RW:0]   trial;

  // one digit step
  always_comb begin
    trial = {1'b0, r_q} + {2'b0, b_q};
    rem_d = rem_q;
    r_d   = r_q >> 1;
    if ({1'b0, rem_q} >= trial) begin
      rem_d = rem_q - trial[RW-1:0];
      r_d   = (r_q >> 1) + {1'b0, b_q};
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && b_q == (RW-1)'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.radicand;
      r_q   <= '0;
      b_q   <= (RW-1)'(1) << (RW - 2);
    end else if (busy_q) begin
      rem_q <= rem_d;
      r_q   <= r_d;
      b_q   <= b_q >> 2;
    end
  end

  // round up when remainder exceeds root
  assign root_o = gmpe_pkg::RootW'(r_q) + gmpe_pkg::RootW'(rem_q > r_q);
  assign done_o = done_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q)
    else $error("sqrt done while still busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) req_i.start |=> busy_q)
    else $error("sqrt did not start");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> $past(busy_q))
    else $error("sqrt done without work");

endmodule

// File: rtl/gmp_model_evaluator.sv
// gmp_model_evaluator: generalized memory polynomial evaluator top level
// depends on gmpe_pkg, gmpe_ram, gmpe_sqrt
//
// Usage: requests arrive on the in_* valid/ready channel. Mode 0 writes one
// complex coefficient into the coefficient memory and completes in the cycle
// it is taken. Mode 1 pushes one complex sample into the history and, once the
// history covers the configured window, produces one complex result on the
// out_* valid/ready channel, the model output for the sample lead_span places
// back. While a sample is evaluated in_ready_o is low.
// Each term runs on one shared multiplier and an iterative square root, and
// terms are summed over the configured set (up to COEF_DEPTH terms). The
// square root's 16 digit steps, the power steps and the multiply sequence
// set how long a term takes. Configuration writes on cfg_* take effect at
// once; the user is to make them only while idle, and the block itself has
// no check for it. Reset clears the history pointer and fill count and sets
// the configuration to its defaults; history and coefficient memories hold
// no reset value. A stalled receiver holds the result in the output register;
// the next sample may still be taken, and its evaluation waits at the end
// until the output register frees.

module gmp_model_evaluator #(
  parameter int unsigned HISTORY_DEPTH = 16,
  parameter int unsigned COEF_DEPTH    = 512,
  parameter int unsigned MAX_ORDER     = 8,
  parameter int unsigned MAX_SPAN      = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                mode_i,
  input  logic [gmpe_pkg::CidxW-1:0]          coef_index_i,
  input  logic signed [gmpe_pkg::CoefW-1:0]   coef_re_i,
  input  logic signed [gmpe_pkg::CoefW-1:0]   coef_im_i,
  input  logic signed [gmpe_pkg::SampleW-1:0] sample_re_i,
  input  logic signed [gmpe_pkg::SampleW-1:0] sample_im_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [gmpe_pkg::SampleW-1:0] out_re_o,
  output logic signed [gmpe_pkg::SampleW-1:0] out_im_o,
  output logic                                clipped_o,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [gmpe_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [gmpe_pkg::CfgW-1:0]           cfg_data_i
);

  localparam int unsigned HAW = $clog2(HISTORY_DEPTH);
  localparam int unsigned FCW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned CAW = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
  localparam int unsigned SLW = $clog2(COEF_DEPTH + 1);
  localparam int unsigned SW  = gmpe_pkg::SampleW;
  localparam int unsigned CW  = gmpe_pkg::CoefW;
  localparam int unsigned MW  = gmpe_pkg::MulW;
  localparam int unsigned PW  = gmpe_pkg::ProdW;
  localparam int unsigned AW  = gmpe_pkg::AccW;

  gmpe_pkg::state_e state_q, state_d;

  // configuration registers
  logic [3:0] ka_q, kb_q, kc_q;
  logic [2:0] ma_q, mb_q, ps_q, mc_q, qs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ka_q <= 4'd1;
      ma_q <= 3'd0;
      kb_q <= 4'd1;
      mb_q <= 3'd0;
      ps_q <= 3'd0;
      kc_q <= 4'd1;
      mc_q <= 3'd0;
      qs_q <= 3'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        gmpe_pkg::CFG_ALIGNED_ORDER: ka_q <= cfg_data_i;
        gmpe_pkg::CFG_ALIGNED_DEPTH: ma_q <= cfg_data_i[2:0];
        gmpe_pkg::CFG_LAG_ORDER:     kb_q <= cfg_data_i;
        gmpe_pkg::CFG_LAG_DEPTH:     mb_q <= cfg_data_i[2:0];
        gmpe_pkg::CFG_LAG_SPAN:      ps_q <= cfg_data_i[2:0];
        gmpe_pkg::CFG_LEAD_ORDER:    kc_q <= cfg_data_i;
        gmpe_pkg::CFG_LEAD_DEPTH:    mc_q <= cfg_data_i[2:0];
        gmpe_pkg::CFG_LEAD_SPAN:     qs_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // clamped orders and spans
  logic [3:0] ka, kb, kc;
  logic [2:0] ps, qs;
  assign ka = (32'(ka_q) > MAX_ORDER) ? 4'(MAX_ORDER) : ka_q;
  assign kb = (32'(kb_q) > MAX_ORDER) ? 4'(MAX_ORDER) : kb_q;
  assign kc = (32'(kc_q) > MAX_ORDER) ? 4'(MAX_ORDER) : kc_q;
  assign ps = (32'(ps_q) > MAX_SPAN) ? 3'(MAX_SPAN) : ps_q;
  assign qs = (32'(qs_q) > MAX_SPAN) ? 3'(MAX_SPAN) : qs_q;

  // window needed before a result is due
  logic [gmpe_pkg::NeedW-1:0] reach, need, lag_reach, lead_reach;
  always_comb begin
    lag_reach  = gmpe_pkg::NeedW'(mb_q) + gmpe_pkg::NeedW'(ps);
    lead_reach = gmpe_pkg::NeedW'(mc_q) + gmpe_pkg::NeedW'(qs);
    reach      = gmpe_pkg::NeedW'(ma_q);
    if (lag_reach > reach) reach = lag_reach;
    if (lead_reach > reach) reach = lead_reach;
    need = gmpe_pkg::NeedW'(qs) + reach + gmpe_pkg::NeedW'(1);
  end

  // request decode
  logic in_acc, coef_wr, push;
  assign in_ready_o = (state_q == gmpe_pkg::S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign coef_wr    = in_acc && (mode_i == gmpe_pkg::MODE_COEF) &&
                      (32'(coef_index_i) < COEF_DEPTH);
  assign push       = in_acc && (mode_i == gmpe_pkg::MODE_SAMPLE);

  // history pointer and fill count
  logic [HAW-1:0] wp_q;
  logic [FCW-1:0] fill_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
    end else if (push) begin
      wp_q <= (32'(wp_q) == HISTORY_DEPTH - 1) ? '0 : wp_q + HAW'(1);
      if (32'(fill_q) < HISTORY_DEPTH) fill_q <= fill_q + FCW'(1);
    end
  end

  // term counters
  gmpe_pkg::sec_e sec_q;
  logic [2:0]     m_q, j_q;
  logic [3:0]     k_q;
  logic [SLW-1:0] slot_q;

  logic [3:0] kmin, kmax;
  logic [2:0] mmax, jmin, jmax;
  always_comb begin
    unique case (sec_q)
      gmpe_pkg::SEC_ALIGNED: begin
        kmin = 4'd1; kmax = ka; mmax = ma_q; jmin = 3'd0; jmax = 3'd0;
      end
      gmpe_pkg::SEC_LAG: begin
        kmin = 4'd2; kmax = kb; mmax = mb_q; jmin = 3'd1; jmax = ps;
      end
      gmpe_pkg::SEC_LEAD: begin
        kmin = 4'd2; kmax = kc; mmax = mc_q; jmin = 3'd1; jmax = qs;
      end
      default: begin
        kmin = 4'd2; kmax = 4'd0; mmax = 3'd0; jmin = 3'd1; jmax = 3'd0;
      end
    endcase
  end

  logic term_ok, terms_end;
  assign term_ok   = (k_q >= kmin) && (k_q <= kmax) && (j_q >= jmin) && (j_q <= jmax);
  assign terms_end = (sec_q == gmpe_pkg::SEC_DONE) || (32'(slot_q) >= COEF_DEPTH);

  // history addresses of the term sample and its envelope sample
  logic [5:0] x_back, e_back;
  always_comb begin
    x_back = 6'(qs) + 6'(m_q);
    unique case (sec_q)
      gmpe_pkg::SEC_LAG:  e_back = x_back + 6'(j_q);
      gmpe_pkg::SEC_LEAD: e_back = x_back - 6'(j_q);
      default:            e_back = x_back;
    endcase
  end

  function automatic logic [HAW-1:0] hist_addr(logic [HAW-1:0] wp, logic [5:0] back);
    logic [7:0] t;
    t = 8'(wp) + 8'(HISTORY_DEPTH - 1) - 8'(back);
    if (32'(t) >= HISTORY_DEPTH) t = t - 8'(HISTORY_DEPTH);
    return HAW'(t);
  endfunction

  // memories
  logic [HAW-1:0]  h_raddr;
  logic [2*SW-1:0] h_rdata;
  logic [2*CW-1:0] c_rdata;

  gmpe_ram #(.WIDTH(2 * SW), .DEPTH(HISTORY_DEPTH)) u_hist (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (wp_q),
    .wdata_i ({sample_re_i, sample_im_i}),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  gmpe_ram #(.WIDTH(2 * CW), .DEPTH(COEF_DEPTH)) u_coef (
    .clk_i   (clk_i),
    .we_i    (coef_wr),
    .waddr_i (CAW'(coef_index_i)),
    .wdata_i ({coef_re_i, coef_im_i}),
    .raddr_i (CAW'(slot_q)),
    .rdata_o (c_rdata)
  );

  assign h_raddr = (state_q == gmpe_pkg::S_ENV_RD) ? hist_addr(wp_q, e_back)
                                                   : hist_addr(wp_q, x_back);

  // square root unit
  gmpe_pkg::sqrt_req_t        sq_req;
  logic                       sq_done;
  logic [gmpe_pkg::RootW-1:0] sq_root;
  logic [gmpe_pkg::RadW-1:0]  rad_q;

  assign sq_req.start    = (state_q == gmpe_pkg::S_SQRT_GO);
  assign sq_req.radicand = rad_q;

  gmpe_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sq_req),
    .done_o (sq_done),
    .root_o (sq_root)
  );

  // datapath registers
  logic [gmpe_pkg::RootW-1:0]         mag_q;
  logic [gmpe_pkg::PwrW-1:0]          p_q;
  logic [3:0]                         cnt_q;
  logic signed [SW-1:0]               tmp_q;
  logic signed [CW-1:0]               cre_q, cim_q;
  logic signed [gmpe_pkg::TermW-1:0]  tre_q, tim_q;
  logic signed [AW-1:0]               acc_re_q, acc_im_q;
  logic signed [PW-1:0]               prod_q;
  logic signed [MW-1:0]               mul_a, mul_b;
  logic signed [SW-1:0]               h_re, h_im;
  logic signed [PW-1:0]               prod_rnd;

  assign h_re     = h_rdata[2*SW-1:SW];
  assign h_im     = h_rdata[SW-1:0];
  assign prod_rnd = (prod_q + PW'(16384)) >>> 15;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      gmpe_pkg::S_SQ_RE:  begin mul_a = MW'(h_re); mul_b = MW'(h_re); end
      gmpe_pkg::S_SQ_IM:  begin mul_a = MW'(tmp_q); mul_b = MW'(tmp_q); end
      gmpe_pkg::S_POW:    begin
        mul_a = signed'(MW'(p_q)); mul_b = signed'(MW'(mag_q));
      end
      gmpe_pkg::S_XT_RE:  begin mul_a = MW'(h_re); mul_b = signed'(MW'(p_q)); end
      gmpe_pkg::S_XT_IM:  begin mul_a = MW'(tmp_q); mul_b = signed'(MW'(p_q)); end
      gmpe_pkg::S_M1:     begin mul_a = MW'(cre_q); mul_b = MW'(tre_q); end
      gmpe_pkg::S_M2:     begin mul_a = MW'(cim_q); mul_b = MW'(tim_q); end
      gmpe_pkg::S_M3:     begin mul_a = MW'(cre_q); mul_b = MW'(tim_q); end
      gmpe_pkg::S_M4:     begin mul_a = MW'(cim_q); mul_b = MW'(tre_q); end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // result rounding and saturation
  logic signed [AW-1:0]    yre_w, yim_w;
  logic signed [SW-1:0]    yre, yim;
  logic                    clip_re, clip_im;
  localparam logic signed [AW-1:0] YMax = AW'(32767);
  localparam logic signed [AW-1:0] YMin = -AW'(32768);
  always_comb begin
    yre_w   = (acc_re_q + AW'(16384)) >>> 15;
    yim_w   = (acc_im_q + AW'(16384)) >>> 15;
    clip_re = (yre_w > YMax) || (yre_w < YMin);
    clip_im = (yim_w > YMax) || (yim_w < YMin);
    yre     = (yre_w > YMax) ? SW'(YMax) : (yre_w < YMin) ? SW'(YMin) : SW'(yre_w);
    yim     = (yim_w > YMax) ? SW'(YMax) : (yim_w < YMin) ? SW'(YMin) : SW'(yim_w);
  end

  // output register
  logic out_valid_q, out_load;
  assign out_load = (state_q == gmpe_pkg::S_FINISH) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_re_o  <= yre;
      out_im_o  <= yim;
      clipped_o <= clip_re || clip_im;
    end
  end

  assign out_valid_o = out_valid_q;

  // sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gmpe_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gmpe_pkg::S_IDLE: begin
        if (push) state_d = gmpe_pkg::S_SETUP;
      end
      gmpe_pkg::S_SETUP: begin
        if (32'(need) > HISTORY_DEPTH || 32'(fill_q) < 32'(need)) begin
          state_d = gmpe_pkg::S_IDLE;
        end else begin
          state_d = gmpe_pkg::S_CHECK;
        end
      end
      gmpe_pkg::S_CHECK: begin
        priority if (terms_end) state_d = gmpe_pkg::S_FINISH;
        else if (term_ok)       state_d = gmpe_pkg::S_ENV_RD;
        else                    state_d = gmpe_pkg::S_ADV;
      end
      gmpe_pkg::S_ADV:     state_d = gmpe_pkg::S_CHECK;
      gmpe_pkg::S_ENV_RD:  state_d = gmpe_pkg::S_SQ_RE;
      gmpe_pkg::S_SQ_RE:   state_d = gmpe_pkg::S_SQ_IM;
      gmpe_pkg::S_SQ_IM:   state_d = gmpe_pkg::S_SQ_SUM;
      gmpe_pkg::S_SQ_SUM:  state_d = gmpe_pkg::S_SQRT_GO;
      gmpe_pkg::S_SQRT_GO: state_d = gmpe_pkg::S_SQRT;
      gmpe_pkg::S_SQRT: begin
        if (sq_done) state_d = gmpe_pkg::S_POW;
      end
      gmpe_pkg::S_POW: begin
        state_d = (cnt_q == 4'd0) ? gmpe_pkg::S_X_RD : gmpe_pkg::S_POW_WR;
      end
      gmpe_pkg::S_POW_WR:  state_d = gmpe_pkg::S_POW;
      gmpe_pkg::S_X_RD:    state_d = gmpe_pkg::S_XT_RE;
      gmpe_pkg::S_XT_RE:   state_d = gmpe_pkg::S_XT_IM;
      gmpe_pkg::S_XT_IM:   state_d = gmpe_pkg::S_M1;
      gmpe_pkg::S_M1:      state_d = gmpe_pkg::S_M2;
      gmpe_pkg::S_M2:      state_d = gmpe_pkg::S_M3;
      gmpe_pkg::S_M3:      state_d = gmpe_pkg::S_M4;
      gmpe_pkg::S_M4:      state_d = gmpe_pkg::S_M5;
      gmpe_pkg::S_M5:      state_d = gmpe_pkg::S_ADV;
      gmpe_pkg::S_FINISH: begin
        if (out_load) state_d = gmpe_pkg::S_IDLE;
      end
      default: state_d = gmpe_pkg::S_IDLE;
    endcase
  end

  // term counters and slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_q  <= gmpe_pkg::SEC_ALIGNED;
      m_q    <= '0;
      k_q    <= 4'd1;
      j_q    <= '0;
      slot_q <= '0;
    end else begin
      unique case (state_q)
        gmpe_pkg::S_SETUP: begin
          sec_q  <= gmpe_pkg::SEC_ALIGNED;
          m_q    <= '0;
          k_q    <= 4'd1;
          j_q    <= '0;
          slot_q <= '0;
        end
        gmpe_pkg::S_M5: slot_q <= slot_q + SLW'(1);
        gmpe_pkg::S_ADV: begin
          priority if (j_q < jmax) begin
            j_q <= j_q + 3'd1;
          end else if (k_q < kmax) begin
            j_q <= jmin;
            k_q <= k_q + 4'd1;
          end else if (m_q < mmax) begin
            j_q <= jmin;
            k_q <= kmin;
            m_q <= m_q + 3'd1;
          end else begin
            // move on to the next term group
            m_q <= '0;
            k_q <= 4'd2;
            j_q <= 3'd1;
            unique case (sec_q)
              gmpe_pkg::SEC_ALIGNED: sec_q <= gmpe_pkg::SEC_LAG;
              gmpe_pkg::SEC_LAG:     sec_q <= gmpe_pkg::SEC_LEAD;
              default:               sec_q <= gmpe_pkg::SEC_DONE;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // arithmetic registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      gmpe_pkg::S_SETUP: begin
        acc_re_q <= '0;
        acc_im_q <= '0;
      end
      gmpe_pkg::S_SQ_RE:  tmp_q <= h_im;
      gmpe_pkg::S_SQ_IM:  rad_q <= gmpe_pkg::RadW'(prod_q);
      gmpe_pkg::S_SQ_SUM: rad_q <= rad_q + gmpe_pkg::RadW'(prod_q);
      gmpe_pkg::S_SQRT: begin
        mag_q <= sq_root;
        p_q   <= gmpe_pkg::PwrOne;
        cnt_q <= k_q - 4'd1;
      end
      gmpe_pkg::S_POW_WR: begin
        p_q   <= gmpe_pkg::PwrW'(prod_rnd);
        cnt_q <= cnt_q - 4'd1;
      end
      gmpe_pkg::S_XT_RE: begin
        tmp_q <= h_im;
        cre_q <= c_rdata[2*CW-1:CW];
        cim_q <= c_rdata[CW-1:0];
      end
      gmpe_pkg::S_XT_IM: tre_q <= gmpe_pkg::TermW'(prod_rnd);
      gmpe_pkg::S_M1:    tim_q <= gmpe_pkg::TermW'(prod_rnd);
      gmpe_pkg::S_M2:    acc_re_q <= acc_re_q + AW'(prod_q);
      gmpe_pkg::S_M3:    acc_re_q <= acc_re_q - AW'(prod_q);
      gmpe_pkg::S_M4:    acc_im_q <= acc_im_q + AW'(prod_q);
      gmpe_pkg::S_M5:    acc_im_q <= acc_im_q + AW'(prod_q);
      default: ;
    endcase
  end

  // checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |-> state_q == gmpe_pkg::S_SQRT)
    else $error("square root finished outside its wait state");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(slot_q) <= COEF_DEPTH)
    else $error("term slot ran past the coefficient store");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= HISTORY_DEPTH && 32'(wp_q) < HISTORY_DEPTH)
    else $error("history pointer or fill count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == gmpe_pkg::S_POW_WR |-> cnt_q != 4'd0)
    else $error("power step with no steps left");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q)
    else $error("result load lost");

endmodule
